FILE: rtl/core/elrb_pkg.sv
// ============================================================================
// elrb_pkg
// Shared types and constants for the event log ring buffer: command codes,
// controller states, field widths and the controller/datapath interface.
// ============================================================================
package elrb_pkg;

    localparam int LOG_DEPTH_DEF = 16;
    localparam int CMD_W         = 2;
    localparam int KIND_W        = 8;
    localparam int TS_W          = 64;
    localparam int WANT_W        = 8;
    localparam int PEND_W        = 5;
    localparam int DROP_W        = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND  = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_START   = 2'd2,
        CMD_STOP    = 2'd3
    } cmd_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic do_append;
        logic do_extract;
        logic do_start;
        logic do_stop;
        logic put_single;
        logic single_err;
        logic put_entry;
        logic pop_out;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic running;
        logic take_zero;
        logic last_entry;
        logic out_busy;
    } sts_t;

endpackage

FILE: rtl/core/elrb_ctrl.sv
// ============================================================================
// elrb_ctrl
// Request decode and extraction sequencing for the event log ring buffer.
// ============================================================================
module elrb_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [elrb_pkg::CMD_W-1:0]     command,
    input  logic                           out_stall,
    input  elrb_pkg::sts_t                 sts,
    output logic                           in_stall,
    output elrb_pkg::ctl_t                 ctl
);

    elrb_pkg::state_t state_reg;
    elrb_pkg::state_t state_next;
    elrb_pkg::cmd_t   cmd;
    logic             slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= elrb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = elrb_pkg::cmd_t'(command);
        slot_free  = !sts.out_busy || !out_stall;
        state_next = state_reg;
        ctl        = '0;
        ctl.pop_out = sts.out_busy && !out_stall;
        in_stall   = 1'b1;

        unique case (state_reg)
            elrb_pkg::ST_IDLE:
            begin
                in_stall   = !slot_free;
                ctl.accept = in_valid && slot_free;
                if (ctl.accept)
                begin
                    unique case (cmd)
                        elrb_pkg::CMD_APPEND:
                        begin
                            ctl.do_append  = sts.running;
                            ctl.put_single = 1'b1;
                            ctl.single_err = !sts.running;
                        end
                        elrb_pkg::CMD_EXTRACT:
                        begin
                            if (!sts.running || sts.take_zero)
                            begin
                                ctl.put_single = 1'b1;
                                ctl.single_err = !sts.running;
                            end
                            else
                            begin
                                ctl.do_extract = 1'b1;
                                state_next     = elrb_pkg::ST_EMIT;
                            end
                        end
                        elrb_pkg::CMD_START:
                        begin
                            // start is ignored while already running
                            ctl.do_start   = !sts.running;
                            ctl.put_single = 1'b1;
                        end
                        elrb_pkg::CMD_STOP:
                        begin
                            ctl.do_stop    = sts.running;
                            ctl.put_single = 1'b1;
                            ctl.single_err = !sts.running;
                        end
                        default:
                        begin
                            ctl.put_single = 1'b1;
                        end
                    endcase
                end
            end
            elrb_pkg::ST_EMIT:
            begin
                if (slot_free)
                begin
                    ctl.put_entry = 1'b1;
                    if (sts.last_entry)
                    begin
                        state_next = elrb_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = elrb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/elrb_dpath.sv
// ============================================================================
// elrb_dpath
// Entry store, head/count/drop registers, read pointer and result register
// of the event log ring buffer.
// ============================================================================
module elrb_dpath
#(
    parameter int LOG_DEPTH = elrb_pkg::LOG_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  elrb_pkg::ctl_t                ctl,
    input  logic [elrb_pkg::KIND_W-1:0]   event_type,
    input  logic [elrb_pkg::TS_W-1:0]     event_time,
    input  logic [elrb_pkg::WANT_W-1:0]   max_entries,
    output elrb_pkg::sts_t                sts,
    output logic                          out_valid,
    output logic                          status,
    output logic                          entry_valid,
    output logic [elrb_pkg::TS_W-1:0]     entry_timestamp,
    output logic [elrb_pkg::KIND_W-1:0]   entry_kind,
    output logic [elrb_pkg::PEND_W-1:0]   pending_count,
    output logic [elrb_pkg::DROP_W-1:0]   dropped_total,
    output logic                          last
);

    localparam int IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W = $clog2(LOG_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [elrb_pkg::TS_W-1:0]   time_mem [LOG_DEPTH];
    logic [elrb_pkg::KIND_W-1:0] kind_mem [LOG_DEPTH];

    logic [IDX_W-1:0]              head_reg,   head_next;
    logic [CNT_W-1:0]              held_reg,   held_next;
    logic [elrb_pkg::DROP_W-1:0]   drop_reg,   drop_next;
    logic                          run_reg,    run_next;
    logic [IDX_W-1:0]              rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]              remain_reg, remain_next;
    logic                          out_valid_reg, out_valid_next;

    logic                          status_reg;
    logic                          ev_reg;
    logic [elrb_pkg::TS_W-1:0]     ts_reg;
    logic [elrb_pkg::KIND_W-1:0]   kind_reg;
    logic                          last_reg;

    logic [elrb_pkg::WANT_W-1:0]   held_w;
    logic [elrb_pkg::WANT_W-1:0]   take_w;
    logic [CNT_W-1:0]              take;
    logic [SUM_W-1:0]              tail_sum;
    logic [IDX_W-1:0]              tail;

    // oldest entry and number of entries this extract takes
    always_comb
    begin
        held_w   = elrb_pkg::WANT_W'(held_reg);
        take_w   = (max_entries < held_w) ? max_entries : held_w;
        take     = CNT_W'(take_w);
        tail_sum = SUM_W'(head_reg) + SUM_W'(LOG_DEPTH) - SUM_W'(held_reg);
        if (tail_sum >= SUM_W'(LOG_DEPTH))
        begin
            tail_sum = tail_sum - SUM_W'(LOG_DEPTH);
        end
        tail = IDX_W'(tail_sum);
    end

    always_comb
    begin
        head_next      = head_reg;
        held_next      = held_reg;
        drop_next      = drop_reg;
        run_next       = run_reg;
        rd_ptr_next    = rd_ptr_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg;

        if (ctl.do_append)
        begin
            head_next = (head_reg == IDX_W'(LOG_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
            if (held_reg == CNT_W'(LOG_DEPTH))
            begin
                drop_next = drop_reg + elrb_pkg::DROP_W'(1);
            end
            else
            begin
                held_next = held_reg + CNT_W'(1);
            end
        end

        if (ctl.do_extract)
        begin
            held_next   = held_reg - take;
            rd_ptr_next = tail;
            remain_next = take;
        end

        if (ctl.put_entry)
        begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(LOG_DEPTH - 1)) ? '0
                                                               : rd_ptr_reg + IDX_W'(1);
            remain_next = remain_reg - CNT_W'(1);
        end

        if (ctl.do_start)
        begin
            head_next = '0;
            held_next = '0;
            drop_next = '0;
            run_next  = 1'b1;
        end

        if (ctl.do_stop)
        begin
            run_next = 1'b0;
        end

        if (ctl.put_single || ctl.put_entry)
        begin
            out_valid_next = 1'b1;
        end
        else if (ctl.pop_out)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            held_reg      <= '0;
            drop_reg      <= '0;
            run_reg       <= 1'b0;
            rd_ptr_reg    <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            held_reg      <= held_next;
            drop_reg      <= drop_next;
            run_reg       <= run_next;
            rd_ptr_reg    <= rd_ptr_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // entry store and result payload, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.do_append)
        begin
            time_mem[head_reg] <= event_time;
            kind_mem[head_reg] <= event_type;
        end
        if (ctl.put_single)
        begin
            status_reg <= ctl.single_err;
            ev_reg     <= 1'b0;
            ts_reg     <= '0;
            kind_reg   <= '0;
            last_reg   <= 1'b1;
        end
        else if (ctl.put_entry)
        begin
            status_reg <= 1'b0;
            ev_reg     <= 1'b1;
            ts_reg     <= time_mem[rd_ptr_reg];
            kind_reg   <= kind_mem[rd_ptr_reg];
            last_reg   <= (remain_reg == CNT_W'(1));
        end
    end

    always_comb
    begin
        sts.running     = run_reg;
        sts.take_zero   = (take == '0);
        sts.last_entry  = (remain_reg == CNT_W'(1));
        sts.out_busy    = out_valid_reg;
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign entry_valid     = ev_reg;
    assign entry_timestamp = ts_reg;
    assign entry_kind      = kind_reg;
    assign last            = last_reg;
    assign pending_count   = run_reg ? elrb_pkg::PEND_W'(held_reg) : '0;
    assign dropped_total   = drop_reg;

endmodule

FILE: rtl/core/event_log_ring_buffer.sv
// ============================================================================
// event_log_ring_buffer
// Timestamped event log in a circular store that overwrites the oldest entry
// when full, with start, stop, append and extract requests.
// ============================================================================
// usage
//   input channel: in_valid/in_stall with command, event_type, event_time
//   and max_entries; output channel: out_valid/out_stall with one result per
//   handshake, last marks the final result of a request
//   append, start and stop give one result, in the cycle after acceptance
//   extract gives one result per removed entry, oldest first, one per cycle
//   unless the output stalls, from the registered read of the entry store,
//   the first one after the read pointer is loaded; an extract that removes
//   nothing (or any request on a stopped log) gives one result in the cycle
//   after acceptance; throughput: one request per cycle for single-result
//   requests unless the output stalls; an extract holds the input while the
//   store's single read port streams the entries out
//   pending_count and dropped_total reflect the state after the request
//   a new request is taken in the cycle its predecessor's last result
//   leaves the output register, so back-to-back requests overlap
//   stalling the output holds the result register and the request input
//   reset clears the log to stopped and empty; entry contents are not
//   cleared and become readable only after being appended again
// ============================================================================
module event_log_ring_buffer
#(
    parameter int LOG_DEPTH = elrb_pkg::LOG_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [elrb_pkg::CMD_W-1:0]    command,
    input  logic [elrb_pkg::KIND_W-1:0]   event_type,
    input  logic [elrb_pkg::TS_W-1:0]     event_time,
    input  logic [elrb_pkg::WANT_W-1:0]   max_entries,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          status,
    output logic                          entry_valid,
    output logic [elrb_pkg::TS_W-1:0]     entry_timestamp,
    output logic [elrb_pkg::KIND_W-1:0]   entry_kind,
    output logic [elrb_pkg::PEND_W-1:0]   pending_count,
    output logic [elrb_pkg::DROP_W-1:0]   dropped_total,
    output logic                          last
);

    elrb_pkg::ctl_t ctl;
    elrb_pkg::sts_t sts;

    // request decode and extraction sequencing
    elrb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .command   (command),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .ctl       (ctl)
    );

    // entry store, counters and result register
    elrb_dpath
    #(
        .LOG_DEPTH (LOG_DEPTH)
    )
    u_dpath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .event_type      (event_type),
        .event_time      (event_time),
        .max_entries     (max_entries),
        .sts             (sts),
        .out_valid       (out_valid),
        .status          (status),
        .entry_valid     (entry_valid),
        .entry_timestamp (entry_timestamp),
        .entry_kind      (entry_kind),
        .pending_count   (pending_count),
        .dropped_total   (dropped_total),
        .last            (last)
    );

    // a request is only taken when the result register can take its result
    a_accept_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> (!out_valid || !out_stall))
        else $error("request accepted while result register blocked");

    // no request is taken while an extraction streams entries
    a_no_accept_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.put_entry |-> !ctl.accept)
        else $error("request accepted during extraction");

    // a non-final extracted entry that leaves is followed by the next entry
    a_entry_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && entry_valid && !last) |=> (out_valid && entry_valid))
        else $error("extraction stream broken");

    // a not-started error result always reports an empty log
    a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (pending_count == '0 && !entry_valid))
        else $error("error result with pending entries");

endmodule

FILE: dv/tb_event_log_ring_buffer.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_event_log_ring_buffer
// Self-checking bench for the event log ring buffer. Directed requests and then
// random bursts are driven while the result side stalls on its own pattern. A
// scoreboard keeps a shadow copy of the log, predicts every result of each
// accepted request and compares the results field by field, in order.
// ============================================================================
module tb_event_log_ring_buffer;

    localparam int DEPTH           = elrb_pkg::LOG_DEPTH_DEF;
    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 11;
    localparam int IDLE_LIMIT      = 1000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int RANDOM_REQUESTS = 384;

    // one result as seen on the output channel
    typedef struct packed {
        logic                        status;
        logic                        entry_valid;
        logic [elrb_pkg::TS_W-1:0]   ts;
        logic [elrb_pkg::KIND_W-1:0] kind;
        logic [elrb_pkg::PEND_W-1:0] pending;
        logic [elrb_pkg::DROP_W-1:0] dropped;
        logic                        last;
    } log_result_t;

    // shadow log plus the queue of results it has predicted
    class log_scoreboard;
        logic [elrb_pkg::TS_W-1:0]   time_copy [DEPTH];
        logic [elrb_pkg::KIND_W-1:0] kind_copy [DEPTH];
        int unsigned                 head;
        int unsigned                 held;
        logic [elrb_pkg::DROP_W-1:0] dropped;
        bit                          running;
        log_result_t                 expected_results [$];
        int unsigned                 errors;

        function new();
            head    = 0;
            held    = 0;
            dropped = '0;
            running = 1'b0;
            errors  = 0;
        endfunction

        // pending and dropped always reflect the state after the whole request
        function void push_result(bit status, bit with_entry,
                                  logic [elrb_pkg::TS_W-1:0] ts,
                                  logic [elrb_pkg::KIND_W-1:0] kind, bit last);
            log_result_t r;
            r.status      = status;
            r.entry_valid = with_entry;
            r.ts          = ts;
            r.kind        = kind;
            r.pending     = running ? elrb_pkg::PEND_W'(held) : '0;
            r.dropped     = dropped;
            r.last        = last;
            expected_results.push_back(r);
        endfunction

        function void note_request(elrb_pkg::cmd_t cmd, logic [elrb_pkg::KIND_W-1:0] kind,
                                   logic [elrb_pkg::TS_W-1:0] ts,
                                   logic [elrb_pkg::WANT_W-1:0] want);
            int unsigned take;
            int unsigned tail;
            case (cmd)
                elrb_pkg::CMD_APPEND:
                begin
                    if (!running)
                    begin
                        push_result(1'b1, 1'b0, '0, '0, 1'b1);
                    end
                    else
                    begin
                        // full log: oldest entry is overwritten and counted
                        if (held >= DEPTH)
                            dropped = dropped + 1'b1;
                        else
                            held = held + 1;
                        time_copy[head] = ts;
                        kind_copy[head] = kind;
                        head = (head + 1) % DEPTH;
                        push_result(1'b0, 1'b0, '0, '0, 1'b1);
                    end
                end
                elrb_pkg::CMD_EXTRACT:
                begin
                    if (!running)
                    begin
                        push_result(1'b1, 1'b0, '0, '0, 1'b1);
                    end
                    else
                    begin
                        take = (want < held) ? want : held;
                        if (take == 0)
                        begin
                            push_result(1'b0, 1'b0, '0, '0, 1'b1);
                        end
                        else
                        begin
                            tail = (head + DEPTH - held) % DEPTH;
                            held = held - take;
                            for (int i = 0; i < take; i++)
                                push_result(1'b0, 1'b1, time_copy[(tail + i) % DEPTH],
                                            kind_copy[(tail + i) % DEPTH], i + 1 == take);
                        end
                    end
                end
                elrb_pkg::CMD_START:
                begin
                    if (!running)
                    begin
                        head    = 0;
                        held    = 0;
                        dropped = '0;
                        running = 1'b1;
                    end
                    push_result(1'b0, 1'b0, '0, '0, 1'b1);
                end
                default:
                begin
                    if (!running)
                    begin
                        push_result(1'b1, 1'b0, '0, '0, 1'b1);
                    end
                    else
                    begin
                        running = 1'b0;
                        push_result(1'b0, 1'b0, '0, '0, 1'b1);
                    end
                end
            endcase
        endfunction

        function void field_check(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(log_result_t got);
            log_result_t exp;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected: expected none, actual st=%0h ev=%0h",
                         $time, got.status, got.entry_valid);
                $display("    ts=%0h kind=%0h pend=%0h drop=%0h last=%0h",
                         got.ts, got.kind, got.pending, got.dropped, got.last);
                return;
            end
            exp = expected_results.pop_front();
            field_check("status", exp.status, got.status);
            field_check("entry_valid", exp.entry_valid, got.entry_valid);
            field_check("entry_timestamp", exp.ts, got.ts);
            field_check("entry_kind", exp.kind, got.kind);
            field_check("pending_count", exp.pending, got.pending);
            field_check("dropped_total", exp.dropped, got.dropped);
            field_check("last", exp.last, got.last);
        endfunction
    endclass

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // every block input starts at a known value
    logic                          in_valid     = 1'b0;
    logic                          in_stall;
    logic [elrb_pkg::CMD_W-1:0]    command      = '0;
    logic [elrb_pkg::KIND_W-1:0]   event_type   = '0;
    logic [elrb_pkg::TS_W-1:0]     event_time   = '0;
    logic [elrb_pkg::WANT_W-1:0]   max_entries  = '0;
    logic                          out_valid;
    logic                          out_stall    = 1'b0;
    logic                          status;
    logic                          entry_valid;
    logic [elrb_pkg::TS_W-1:0]     entry_timestamp;
    logic [elrb_pkg::KIND_W-1:0]   entry_kind;
    logic [elrb_pkg::PEND_W-1:0]   pending_count;
    logic [elrb_pkg::DROP_W-1:0]   dropped_total;
    logic                          last;

    log_scoreboard sb;

    event_log_ring_buffer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .event_type      (event_type),
        .event_time      (event_time),
        .max_entries     (max_entries),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .entry_valid     (entry_valid),
        .entry_timestamp (entry_timestamp),
        .entry_kind      (entry_kind),
        .pending_count   (pending_count),
        .dropped_total   (dropped_total),
        .last            (last)
    );

    // single reset pulse at the start of the run
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    // result side stall pattern: switches at random between free flow, light
    // random, periodic and heavy random stalling
    int unsigned stall_mode = 0;
    int unsigned phase_left = 0;
    int unsigned rx_tick    = 0;

    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (phase_left == 0)
        begin
            phase_left <= $urandom_range(40, 200);
            stall_mode <= $urandom_range(0, 3);
        end
        else
        begin
            phase_left <= phase_left - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 99) < 30);
            2:       out_stall <= ((rx_tick % 7) < 3);
            default: out_stall <= ($urandom_range(0, 99) < 75);
        endcase
    end

    // monitor: both handshakes are sampled at the edge, before any update
    always @(posedge clk)
    begin : monitor
        log_result_t seen;
        if (rst_n)
        begin
            // a request is noted before any result of the same edge is checked
            if (in_valid && !in_stall)
                sb.note_request(elrb_pkg::cmd_t'(command), event_type, event_time,
                                max_entries);
            if (out_valid && !out_stall)
            begin
                seen.status      = status;
                seen.entry_valid = entry_valid;
                seen.ts          = entry_timestamp;
                seen.kind        = entry_kind;
                seen.pending     = pending_count;
                seen.dropped     = dropped_total;
                seen.last        = last;
                sb.check_result(seen);
            end
        end
    end

    // watchdog on cycles where neither channel moves anything
    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // present one request and hold it until the block takes it
    task automatic send_request(elrb_pkg::cmd_t cmd, logic [elrb_pkg::KIND_W-1:0] kind,
                                logic [elrb_pkg::TS_W-1:0] ts,
                                logic [elrb_pkg::WANT_W-1:0] want);
        command     <= cmd;
        event_type  <= kind;
        event_time  <= ts;
        max_entries <= want;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic idle_sender(int unsigned cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // hold off new requests until every predicted result has been seen
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0)
            @(posedge clk);
    endtask

    // mostly well-formed traffic on a running log, with stops, restarts and
    // requests on a stopped log mixed in as noise
    task automatic random_phase(int unsigned count);
        int unsigned                 sent;
        int unsigned                 burst;
        int unsigned                 pick;
        elrb_pkg::cmd_t              cmd;
        logic [elrb_pkg::WANT_W-1:0] want;
        logic [elrb_pkg::TS_W-1:0]   ts;
        logic [elrb_pkg::TS_W-1:0]   stamp_clock;
        sent        = 0;
        stamp_clock = '0;
        while (sent < count)
        begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < count; b++)
            begin
                pick = $urandom_range(0, 99);
                if (!sb.running)
                    cmd = (pick < 70) ? elrb_pkg::CMD_START :
                          (pick < 80) ? elrb_pkg::CMD_APPEND :
                          (pick < 90) ? elrb_pkg::CMD_EXTRACT : elrb_pkg::CMD_STOP;
                else
                    cmd = (pick < 58) ? elrb_pkg::CMD_APPEND :
                          (pick < 85) ? elrb_pkg::CMD_EXTRACT :
                          (pick < 93) ? elrb_pkg::CMD_STOP : elrb_pkg::CMD_START;

                // small extracts let the log fill up and wrap
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    want = elrb_pkg::WANT_W'($urandom_range(0, 3));
                else if (pick < 8)
                    want = elrb_pkg::WANT_W'($urandom_range(0, 255));
                else if (pick == 8)
                    want = 8'hff;
                else
                    want = '0;

                // either full-range stamps or a monotonic millisecond clock
                stamp_clock = stamp_clock + $urandom_range(1, 50);
                ts = $urandom_range(0, 1) ? {$urandom, $urandom} : stamp_clock;

                send_request(cmd, elrb_pkg::KIND_W'($urandom_range(0, 255)), ts, want);
                sent++;

                // occasional full pause until the result side catches up
                if (sent % 150 == 75)
                    wait_drained();
            end
            idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        end
    endtask

    initial
    begin
        sb = new();
        while (!rst_n)
            @(posedge clk);
        @(posedge clk);

        // requests on a stopped log, double start, extract from an empty log
        send_request(elrb_pkg::CMD_APPEND, 8'h5a, 64'd1, 8'd0);
        send_request(elrb_pkg::CMD_EXTRACT, 8'h00, 64'd0, 8'd255);
        send_request(elrb_pkg::CMD_STOP, 8'h00, 64'd0, 8'd0);
        send_request(elrb_pkg::CMD_START, 8'h00, 64'd0, 8'd0);
        send_request(elrb_pkg::CMD_START, 8'hff, '1, 8'hff);
        send_request(elrb_pkg::CMD_EXTRACT, 8'h00, 64'd0, 8'd255);

        // one append past full overwrites the oldest entry, field extremes at the ends
        for (int n = 0; n <= DEPTH; n++)
            send_request(elrb_pkg::CMD_APPEND,
                         (n == 0) ? 8'h00 : (n == DEPTH) ? 8'hff : 8'($urandom_range(0, 255)),
                         (n == 0) ? 64'd0 : (n == DEPTH) ? '1 : {$urandom, $urandom},
                         8'd0);

        // zero-size extract, then drain the whole log, then stop with drops kept
        send_request(elrb_pkg::CMD_EXTRACT, 8'h00, 64'd0, 8'd0);
        send_request(elrb_pkg::CMD_EXTRACT, 8'h00, 64'd0, 8'd255);
        send_request(elrb_pkg::CMD_STOP, 8'h00, 64'd0, 8'd0);
        wait_drained();

        random_phase(RANDOM_REQUESTS);

        // let everything outstanding come back, then watch for stray results
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: event_log_ring_buffer.f
rtl/core/elrb_pkg.sv
rtl/core/elrb_ctrl.sv
rtl/core/elrb_dpath.sv
rtl/core/event_log_ring_buffer.sv
dv/tb_event_log_ring_buffer.sv
